>>> src/rmc_pkg.sv
`timescale 1ns / 1ps

package rmc_pkg;

    // Default depth of the received-line store.
    localparam int RX_STORE_DEPTH_DEF = 128;

    // Reset value of the idle limit register.
    localparam logic [7:0] IDLE_LIMIT_RST = 8'd4;

    // Character codes used by the parser.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4d;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] SAT_TICKS = 8'hff;

    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_TICK   = 3'd1,
        KIND_REARM  = 3'd2,
        KIND_TXHOLD = 3'd3,
        KIND_READ   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_DATA    = 3'd1,
        PH_CK_HIGH = 3'd2,
        PH_CK_LOW  = 3'd3,
        PH_WAIT_LF = 3'd4,
        PH_GOOD    = 3'd5,
        PH_ERROR   = 3'd6,
        PH_TX_HOLD = 3'd7
    } phase_t;

    // Write request from the parser to the line store.
    typedef struct packed {
        logic       mem_we;  // write the main array at the given address
        logic       e0_we;   // write the separate entry-zero register
        logic [7:0] data;
    } store_wr_t;

    // Parser state after an item, as reported on the result channel.
    typedef struct packed {
        phase_t     phase;
        logic [6:0] byte_count;
        logic [7:0] running_xor;
    } parse_stat_t;

    // Expected header character at store positions 1 through 7.
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd1:    ch = CH_DOLLAR;
            3'd2:    ch = CH_G;
            3'd3:    ch = CH_P;
            3'd4:    ch = CH_R;
            3'd5:    ch = CH_M;
            3'd6:    ch = CH_C;
            3'd7:    ch = CH_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Uppercase ASCII hex digit of the low nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib > 4'd9) begin
            ch = {4'h0, nib} + CH_SEVEN;
        end else begin
            ch = {4'h0, nib} + CH_ZERO;
        end
        return ch;
    endfunction

endpackage

>>> src/nmea_rmc_sentence_checker_top.sv
`timescale 1ns / 1ps

// NMEA RMC sentence checker.
// The slave stream carries one item per received character, timer tick or
// software request. s_tuser holds the kind (byte, tick, rearm, transmit hold,
// read store); s_tdata holds the received character and the store index to
// read. The master stream returns exactly one item per input item: the parser
// phase, the store position, the running XOR of the sentence body and the
// byte read from the line store (zero unless the item was a read).
// The cfg channel writes the idle limit, the number of silent ticks beyond
// which the next byte restarts the line; it is always ready and should be
// written only while no item is in flight.
// An accepted item sits in the input stage (with its line-store read done as it
// is accepted), and its result is then loaded into the output register. The
// block takes one item every cycle while m_tready stays high; the registered
// read port of the line store sets the input stage.
// When the receiver stalls, the output register holds its result and the input
// stage holds one more item, then s_tready drops until m_tready returns.
// Synchronous reset returns the parser to hunting for a header, clears the
// position, checksum and silence count, restores the idle limit to 4 and
// empties both stages. The line store contents are not cleared.
module nmea_rmc_sentence_checker_top #(
    parameter int RX_STORE_DEPTH = rmc_pkg::RX_STORE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
    input  logic [2:0]  s_tuser,   // [2:0] kind
    // Result item channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] parse_state, [9:3] byte_count,
                                   // [17:10] running_xor, [25:18] read_data,
                                   // [31:26] zero
    // Idle limit register write.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import rmc_pkg::*;

    localparam int AW = $clog2(RX_STORE_DEPTH);

    logic          s_acc;
    logic          adv;
    logic [7:0]    idle_limit_reg;

    // Input stage.
    logic          v1_reg;
    kind_t         kind1_reg;
    logic [7:0]    rx1_reg;

    // Output stage.
    logic          vo_reg;
    parse_stat_t   stat_o_reg;
    logic [7:0]    rdata_o_reg;

    parse_stat_t   stat;
    store_wr_t     wr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_data;

    // The input stage moves on whenever the output register is empty or
    // being drained in this cycle.
    assign adv      = v1_reg && (!vo_reg || m_tready);
    assign s_tready = !v1_reg || adv;
    assign s_acc    = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_limit_reg <= IDLE_LIMIT_RST;
        end else if (cfg_valid) begin
            idle_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                v1_reg <= 1'b1;
            end else if (adv) begin
                v1_reg <= 1'b0;
            end
            if (adv) begin
                vo_reg <= 1'b1;
            end else if (m_tready) begin
                vo_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            kind1_reg <= kind_t'(s_tuser);
            rx1_reg   <= s_tdata[7:0];
        end
        if (adv) begin
            stat_o_reg  <= stat;
            rdata_o_reg <= (kind1_reg == KIND_READ) ? rd_data : 8'h00;
        end
    end

    rmc_parser #(
        .RX_STORE_DEPTH (RX_STORE_DEPTH),
        .AW             (AW)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .go         (adv),
        .kind       (kind1_reg),
        .rx_byte    (rx1_reg),
        .idle_limit (idle_limit_reg),
        .stat       (stat),
        .wr         (wr),
        .wr_addr    (wr_addr)
    );

    // The store is read as the item is accepted, so the byte is ready when
    // the item leaves the input stage.
    rmc_line_store #(
        .RX_STORE_DEPTH (RX_STORE_DEPTH),
        .AW             (AW)
    ) u_store (
        .aclk     (aclk),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .rd_en    (s_acc),
        .rd_index (s_tdata[14:8]),
        .rd_data  (rd_data)
    );

    assign m_tvalid = vo_reg;
    assign m_tdata  = {6'b0, rdata_o_reg, stat_o_reg.running_xor,
                       stat_o_reg.byte_count, stat_o_reg.phase};

    // A rearm always reports the hunting phase at position zero.
    a_rearm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && kind1_reg == KIND_REARM) |=>
            (m_tvalid && m_tdata[2:0] == PH_HEADER && m_tdata[9:3] == 7'd0))
        else $error("rearm did not return parser to header hunting");

    // Only read items carry store data.
    a_read_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && kind1_reg != KIND_READ) |=> (m_tdata[25:18] == 8'h00))
        else $error("read_data nonzero on a non-read item");

    // Transmit hold is reported right after a hold item.
    a_tx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && kind1_reg == KIND_TXHOLD) |=> (m_tdata[2:0] == PH_TX_HOLD))
        else $error("transmit hold not reported");

    // An input stage that is empty never blocks the input channel.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg) |-> s_tready)
        else $error("input stalled while input stage empty");

endmodule

>>> src/rmc_line_store.sv
`timescale 1ns / 1ps

module rmc_line_store #(
    parameter int RX_STORE_DEPTH = rmc_pkg::RX_STORE_DEPTH_DEF,
    parameter int AW             = $clog2(RX_STORE_DEPTH)
) (
    input  logic                    aclk,
    input  rmc_pkg::store_wr_t      wr,
    input  logic [AW-1:0]           wr_addr,
    input  logic                    rd_en,
    input  logic [6:0]              rd_index,
    output logic [7:0]              rd_data
);
    import rmc_pkg::*;

    localparam int PW = (AW > 7) ? AW : 7;

    // Entry zero lives in its own register, because a wrapping byte writes
    // both the last entry and entry zero in the same cycle.
    logic [7:0]    mem [RX_STORE_DEPTH];
    logic [7:0]    e0_reg;
    logic [7:0]    e0_now;
    logic [7:0]    rd_reg;
    logic [PW-1:0] idx_w;
    logic [AW-1:0] rd_addr;
    logic          in_range;
    logic          hit;

    assign idx_w    = PW'(rd_index);
    assign rd_addr  = idx_w[AW-1:0];
    assign in_range = (PW+1)'(rd_index) < (PW+1)'(RX_STORE_DEPTH);
    assign e0_now   = wr.e0_we ? wr.data : e0_reg;
    // A read in the same cycle as a write to that entry sees the new byte.
    assign hit      = wr.mem_we && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr.mem_we) begin
            mem[wr_addr] <= wr.data;
        end
        if (wr.e0_we) begin
            e0_reg <= wr.data;
        end
        if (rd_en) begin
            if (!in_range) begin
                rd_reg <= 8'h00;
            end else if (rd_index == 7'd0) begin
                rd_reg <= e0_now;
            end else if (hit) begin
                rd_reg <= wr.data;
            end else begin
                rd_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_reg;

endmodule

>>> src/rmc_parser.sv
`timescale 1ns / 1ps

module rmc_parser #(
    parameter int RX_STORE_DEPTH = rmc_pkg::RX_STORE_DEPTH_DEF,
    parameter int AW             = $clog2(RX_STORE_DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    input  rmc_pkg::kind_t        kind,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            idle_limit,
    output rmc_pkg::parse_stat_t  stat,
    output rmc_pkg::store_wr_t    wr,
    output logic [AW-1:0]         wr_addr
);
    import rmc_pkg::*;

    localparam int            PW   = (AW > 7) ? AW : 7;
    localparam logic [AW-1:0] LAST = AW'(RX_STORE_DEPTH - 1);

    phase_t        phase_reg, phase_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [7:0]    xor_reg, xor_next;
    logic [7:0]    silent_reg, silent_next;
    logic [AW-1:0] pos_pre;
    logic [AW-1:0] pos_adv;
    logic [PW-1:0] pos_w;
    logic          hdr_ok;

    // Position after a silence check, and after the store pointer moves on.
    assign pos_pre = (silent_reg > idle_limit) ? '0 : pos_reg;
    assign pos_adv = (pos_pre == LAST) ? '0 : pos_pre + AW'(1);
    assign hdr_ok  = (pos_adv >= AW'(1)) && (pos_adv <= AW'(7)) &&
                     (rx_byte == hdr_char(pos_adv[2:0]));

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        silent_next = silent_reg;
        wr          = '0;
        wr.data     = rx_byte;
        if (go) begin
            unique case (kind)
                KIND_BYTE: begin
                    if (phase_reg != PH_TX_HOLD) begin
                        silent_next = 8'h00;
                        wr.mem_we   = (pos_pre != '0);
                        wr.e0_we    = (pos_pre == '0) || (pos_pre == LAST);
                        pos_next    = pos_adv;
                        unique case (phase_reg)
                            PH_HEADER: begin
                                if (hdr_ok) begin
                                    xor_next = (pos_adv <= AW'(2)) ? rx_byte
                                                                   : xor_reg ^ rx_byte;
                                    if (pos_adv == AW'(7)) begin
                                        phase_next = PH_DATA;
                                    end
                                end else begin
                                    pos_next = '0;
                                end
                            end
                            PH_DATA: begin
                                if (rx_byte == CH_STAR) begin
                                    phase_next = PH_CK_HIGH;
                                end else begin
                                    xor_next = xor_reg ^ rx_byte;
                                end
                            end
                            PH_CK_HIGH: begin
                                phase_next = (hex_digit(xor_reg[7:4]) == rx_byte) ?
                                             PH_CK_LOW : PH_ERROR;
                            end
                            PH_CK_LOW: begin
                                phase_next = (hex_digit(xor_reg[3:0]) == rx_byte) ?
                                             PH_WAIT_LF : PH_ERROR;
                            end
                            PH_WAIT_LF: begin
                                if (rx_byte == CH_LF) begin
                                    phase_next = PH_GOOD;
                                end
                            end
                            PH_GOOD: begin
                                phase_next = PH_GOOD;
                            end
                            default: begin
                                phase_next = PH_HEADER;
                                pos_next   = '0;
                            end
                        endcase
                    end
                end
                KIND_TICK: begin
                    if (silent_reg != SAT_TICKS) begin
                        silent_next = silent_reg + 8'd1;
                    end
                end
                KIND_REARM: begin
                    phase_next = PH_HEADER;
                    pos_next   = '0;
                end
                KIND_TXHOLD: begin
                    phase_next = PH_TX_HOLD;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            xor_reg    <= 8'h00;
            silent_reg <= 8'h00;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            xor_reg    <= xor_next;
            silent_reg <= silent_next;
        end
    end

    assign wr_addr          = pos_pre;
    assign pos_w            = PW'(pos_next);
    assign stat.phase       = phase_next;
    assign stat.byte_count  = pos_w[6:0];
    assign stat.running_xor = xor_next;

endmodule
